// ===== rtl/sgs_pkg.sv =====
// sgs_pkg: shared types, widths and coefficient tables of the savitzky-golay smoother
// depends on nothing; every rtl file imports it
`default_nettype none

package sgs_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_TAPS    = 15;
  localparam int NUM_MODES   = 6;
  localparam int MODE_W      = 3;
  localparam int COUNT_W     = 5;

  // widest mode that fits in the delay line
  localparam int MODE_FIT_RAW = (MAX_TAPS - 5) / 2;
  localparam int MODE_FIT     = (MODE_FIT_RAW < NUM_MODES - 1) ? MODE_FIT_RAW : NUM_MODES - 1;
  localparam int HALF_MAX     = MODE_FIT + 2;
  localparam int NUM_PAIRS    = HALF_MAX + 1;
  localparam int NUM_GRP      = (NUM_PAIRS + 1) / 2;
  localparam int NUM_PROD     = 2 * NUM_GRP;
  localparam int HALF_W       = $clog2(HALF_MAX + 1);

  localparam int COEF_W  = 9;
  localparam int NORM_W  = 11;
  localparam int PAIR_W  = SAMPLE_BITS + 1;
  localparam int PROD_W  = PAIR_W + COEF_W;
  localparam int SUM_W   = SAMPLE_BITS + 11;
  localparam int MAG_W   = SAMPLE_BITS + 10;
  localparam int RECIP_W = MAG_W - 4;
  localparam int QUO_W   = MAG_W - 4;
  localparam int PRD_W   = MAG_W + RECIP_W;
  localparam int QN_W    = QUO_W + NORM_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [QUO_W-1:0] NEG_LIMIT = QUO_W'(1) << (SAMPLE_BITS - 1);
  localparam logic [QUO_W-1:0] POS_LIMIT = NEG_LIMIT - QUO_W'(1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam sample_t SAMPLE_HI = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam sample_t SAMPLE_LO = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  // symmetric quadratic weights, centre tap first
  localparam int COEF [NUM_MODES][8] = '{
    '{17, 12, -3, 0, 0, 0, 0, 0},
    '{7, 6, 3, -2, 0, 0, 0, 0},
    '{59, 54, 39, 14, -21, 0, 0, 0},
    '{89, 84, 69, 44, 9, -36, 0, 0},
    '{25, 24, 21, 16, 9, 0, -11, 0},
    '{167, 162, 147, 122, 87, 42, -13, -78}
  };

  localparam int NORM [NUM_MODES] = '{35, 21, 231, 429, 143, 1105};

  localparam int HALF_NORM [NUM_MODES] = '{35 / 2, 21 / 2, 231 / 2, 429 / 2, 143 / 2, 1105 / 2};

  // floor(2^MAG_W / norm); quotient estimate is low by at most one
  localparam logic [RECIP_W-1:0] RECIP [NUM_MODES] = '{
    RECIP_W'((64'd1 << MAG_W) / 64'd35),
    RECIP_W'((64'd1 << MAG_W) / 64'd21),
    RECIP_W'((64'd1 << MAG_W) / 64'd231),
    RECIP_W'((64'd1 << MAG_W) / 64'd429),
    RECIP_W'((64'd1 << MAG_W) / 64'd143),
    RECIP_W'((64'd1 << MAG_W) / 64'd1105)
  };

  typedef struct packed {
    sample_t sample;
    logic    end_of_record;
  } sgs_in_t;

  typedef struct packed {
    sample_t smoothed;
    logic    last_out;
  } sgs_out_t;

  // per-beat control that rides along the arithmetic pipeline
  typedef struct packed {
    logic              valid;
    logic              raw;
    logic              last;
    logic [MODE_W-1:0] mode;
    sample_t           raw_value;
  } sgs_tag_t;

  function automatic logic [MODE_W-1:0] eff_mode(input logic [MODE_W-1:0] wm);
    logic [MODE_W-1:0] m;
    m = wm;
    if (m > MODE_W'(MODE_FIT)) begin
      m = MODE_W'(MODE_FIT);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sgs_cell.sv =====
// sgs_cell: one tap of the sample delay line, loads its neighbor's sample (cell 0: the new one) on each beat
// depends on sgs_pkg
`default_nettype none

module sgs_cell import sgs_pkg::*; (
  input  logic    clk,
  input  logic    shift,
  input  sample_t d,
  output sample_t q
);

  sample_t held;

  always_ff @(posedge clk) begin
    if (shift) begin
      held <= d;
    end
  end

  assign q = held;

endmodule

`default_nettype wire

// ===== rtl/sgs_mac.sv =====
// sgs_mac: symmetric pre-add, constant-weight multiply and adder tree (four stages)
// depends on sgs_pkg
`default_nettype none

module sgs_mac import sgs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  sample_t                  window [MAX_TAPS],
  input  sgs_tag_t                 tag_in,
  output logic signed [SUM_W-1:0]  sum,
  output sgs_tag_t                 tag_out
);

  logic signed [PAIR_W-1:0] pair_next [NUM_PAIRS];
  logic signed [PAIR_W-1:0] pair      [NUM_PAIRS];
  logic signed [PROD_W-1:0] prod_next [NUM_PROD];
  logic signed [PROD_W-1:0] prod      [NUM_PROD];
  logic signed [SUM_W-1:0]  grp_next  [NUM_GRP];
  logic signed [SUM_W-1:0]  grp       [NUM_GRP];
  logic signed [SUM_W-1:0]  sum_next;
  sgs_tag_t tag1, tag2, tag3;

  // pair the taps at equal distance from the centre of the selected window
  always_comb begin
    for (int d = 0; d < NUM_PAIRS; d++) begin
      pair_next[d] = '0;
    end
    for (int mm = 0; mm <= MODE_FIT; mm++) begin
      if (tag_in.mode == MODE_W'(mm)) begin
        pair_next[0] = PAIR_W'(window[mm + 2]);
        for (int d = 1; d <= mm + 2; d++) begin
          pair_next[d] = PAIR_W'(window[mm + 2 - d]) + PAIR_W'(window[mm + 2 + d]);
        end
      end
    end
  end

  always_comb begin
    for (int d = 0; d < NUM_PROD; d++) begin
      prod_next[d] = '0;
    end
    for (int d = 0; d < NUM_PAIRS; d++) begin
      prod_next[d] = PROD_W'(pair[d]) * PROD_W'(COEF[tag1.mode][d]);
    end
  end

  always_comb begin
    for (int g = 0; g < NUM_GRP; g++) begin
      grp_next[g] = SUM_W'(prod[2 * g]) + SUM_W'(prod[2 * g + 1]);
    end
  end

  always_comb begin
    sum_next = '0;
    for (int g = 0; g < NUM_GRP; g++) begin
      sum_next = sum_next + grp[g];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1    <= '0;
      tag2    <= '0;
      tag3    <= '0;
      tag_out <= '0;
    end else if (en) begin
      tag1    <= tag_in;
      tag2    <= tag1;
      tag3    <= tag2;
      tag_out <= tag3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pair <= pair_next;
      prod <= prod_next;
      grp  <= grp_next;
      sum  <= sum_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sgs_scale.sv =====
// sgs_scale: divide by the window norm with round-half-away, then saturate (five stages)
// depends on sgs_pkg
`default_nettype none

module sgs_scale import sgs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic signed [SUM_W-1:0] sum,
  input  sgs_tag_t                tag_in,
  output sample_t                 value,
  output sgs_tag_t                tag_out
);

  sgs_tag_t tag5, tag6, tag7, tag8;

  logic [MAG_W-1:0] mag5, mag5_next, mag6, mag7;
  logic             neg5, neg6, neg7, neg8;
  logic [PRD_W-1:0] prd6, prd6_next;
  logic [QUO_W-1:0] q0_7, q0_7_next;
  logic [MAG_W-1:0] qn7, qn7_next;
  logic [MAG_W-1:0] rem8;
  logic [QUO_W-1:0] q8, q8_next;
  sample_t          value_next;

  // magnitude plus half the norm
  assign mag5_next = ((sum < 0) ? MAG_W'(-sum) : MAG_W'(sum)) +
                     MAG_W'(HALF_NORM[tag_in.mode]);

  // reciprocal multiply
  assign prd6_next = PRD_W'(mag5) * PRD_W'(RECIP[tag5.mode]);

  // quotient estimate and its product with the norm
  assign q0_7_next = prd6[MAG_W +: QUO_W];
  assign qn7_next  = MAG_W'(QN_W'(q0_7_next) * QN_W'(NORM[tag6.mode]));

  // remainder in [0, 2*norm): one correction step
  assign rem8    = mag7 - qn7;
  assign q8_next = (rem8 >= MAG_W'(NORM[tag7.mode])) ? q0_7 + QUO_W'(1) : q0_7;

  always_comb begin
    if (!neg8) begin
      value_next = (q8 > POS_LIMIT) ? SAMPLE_HI : $signed(q8[SAMPLE_BITS-1:0]);
    end else begin
      value_next = (q8 >= NEG_LIMIT) ? SAMPLE_LO : -$signed(q8[SAMPLE_BITS-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag5    <= '0;
      tag6    <= '0;
      tag7    <= '0;
      tag8    <= '0;
      tag_out <= '0;
    end else if (en) begin
      tag5    <= tag_in;
      tag6    <= tag5;
      tag7    <= tag6;
      tag8    <= tag7;
      tag_out <= tag8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag5  <= mag5_next;
      neg5  <= (sum < 0);
      prd6  <= prd6_next;
      mag6  <= mag5;
      neg6  <= neg5;
      q0_7  <= q0_7_next;
      qn7   <= qn7_next;
      mag7  <= mag6;
      neg7  <= neg6;
      q8    <= q8_next;
      neg8  <= neg7;
      value <= value_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/savitzky_golay_smoother_unit.sv =====
// savitzky_golay_smoother_unit: top level of the quadratic savitzky-golay smoother
// depends on sgs_pkg, sgs_cell, sgs_mac, sgs_scale
//
// usage
//   feed carries one signed sample per beat (valid/ready); end_of_record marks the
//   last sample of a record. result carries one smoothed sample per beat; last_out
//   marks the final result of the record. cfg_we/cfg_wdata write window_mode
//   (0..5 -> 5..15 points; 6 and 7 act as 15) and take effect on the next beat.
//   write it only between records, once all results have been taken.
// throughput
//   one sample per cycle inside a record while the skid register is empty. the
//   beat that carries end_of_record is followed by a flush with feed_ready low
//   that sends min(samples seen, h) held samples as raw results (h = half window, 2..7).
// pipeline
//   a result passes from the beat that completes its window through four stages of
//   pre-add/multiply/tree, five of norm division and saturation, and the output
//   register. results trail the input stream by h samples.
// stalls
//   when the receiver stalls, one more result is caught in a skid register and
//   then the whole pipeline and feed_ready hold until result_ready returns.
// reset
//   synchronous; clears the mode to 5 points, the record count, the flush count
//   and all pipeline valid bits. the delay line is not cleared; it is refilled
//   by every record before it is read.
`default_nettype none

module savitzky_golay_smoother_unit import sgs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [MODE_W-1:0] cfg_wdata,
  input  logic              feed_valid,
  output logic              feed_ready,
  input  sgs_in_t           feed,
  output logic              result_valid,
  input  logic              result_ready,
  output sgs_out_t          result
);

  // configuration and record state
  logic [MODE_W-1:0]  window_mode;
  logic [MODE_W-1:0]  mode;
  logic [COUNT_W-1:0] seen;
  logic [COUNT_W-1:0] seen_inc;
  logic [COUNT_W-1:0] half;
  logic               emit;
  logic               smooth;
  logic [HALF_W-1:0]  flush_count;
  logic [HALF_W-1:0]  flush_len;

  // handshake
  logic adv;
  logic accept;

  // delay line: line is what the cells hold, window is the view after this beat's shift
  sample_t line   [MAX_TAPS];
  sample_t window [MAX_TAPS];
  sample_t center;
  sample_t flush_value;

  // pipeline
  sgs_tag_t                tag_in;
  sgs_tag_t                tag_mac;
  sgs_tag_t                tag_pipe;
  logic signed [SUM_W-1:0] sum;
  sample_t                 value;
  sgs_out_t                pipe_beat;
  logic                    push;

  // output skid
  logic     skid_valid;
  sgs_out_t skid_data;

  // the whole pipeline moves unless the skid register is occupied
  assign adv        = !skid_valid;
  assign feed_ready = adv && (flush_count == '0);
  assign accept     = feed_valid && feed_ready;

  assign mode     = eff_mode(window_mode);
  assign half     = COUNT_W'(mode) + COUNT_W'(2);
  assign seen_inc = (seen != COUNT_MAX) ? seen + COUNT_W'(1) : seen;
  assign emit     = seen_inc > half;
  assign smooth   = seen_inc > {half[COUNT_W-2:0], 1'b0};
  assign flush_len = HALF_W'((seen_inc < half) ? seen_inc : half);

  // chain of delay cells, newest sample in cell 0
  assign window[0] = feed.sample;

  for (genvar k = 1; k < MAX_TAPS; k++) begin : g_view
    assign window[k] = line[k - 1];
  end

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    sgs_cell u_cell (
      .clk   (clk),
      .shift (accept),
      .d     (window[k]),
      .q     (line[k])
    );
  end

  // raw centre sample for results near the start of a record
  always_comb begin
    center = window[2];
    for (int mm = 0; mm <= MODE_FIT; mm++) begin
      if (mode == MODE_W'(mm)) begin
        center = window[mm + 2];
      end
    end
  end

  // held sample sent during the flush, oldest first
  always_comb begin
    flush_value = line[0];
    for (int k = 1; k <= HALF_MAX; k++) begin
      if (flush_count == HALF_W'(k)) begin
        flush_value = line[k - 1];
      end
    end
  end

  // pipeline entry: an accepted sample or one flush beat
  always_comb begin
    tag_in.mode = mode;
    if (flush_count != '0) begin
      tag_in.valid     = 1'b1;
      tag_in.raw       = 1'b1;
      tag_in.last      = (flush_count == HALF_W'(1));
      tag_in.raw_value = flush_value;
    end else begin
      tag_in.valid     = accept && emit;
      tag_in.raw       = !smooth;
      tag_in.last      = 1'b0;
      tag_in.raw_value = center;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_mode <= '0;
      seen        <= '0;
      flush_count <= '0;
    end else begin
      if (cfg_we) begin
        window_mode <= cfg_wdata;
      end
      if (accept) begin
        seen <= feed.end_of_record ? '0 : seen_inc;
      end
      if (accept && feed.end_of_record) begin
        flush_count <= flush_len;
      end else if ((flush_count != '0) && adv) begin
        flush_count <= flush_count - HALF_W'(1);
      end
    end
  end

  sgs_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .window  (window),
    .tag_in  (tag_in),
    .sum     (sum),
    .tag_out (tag_mac)
  );

  sgs_scale u_scale (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .sum     (sum),
    .tag_in  (tag_mac),
    .value   (value),
    .tag_out (tag_pipe)
  );

  // edge samples bypass the arithmetic result
  assign pipe_beat.smoothed = tag_pipe.raw ? tag_pipe.raw_value : value;
  assign pipe_beat.last_out = tag_pipe.last;
  assign push               = adv && tag_pipe.valid;

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      if (result_valid && !result_ready) begin
        if (push) begin
          skid_valid <= 1'b1;
        end
      end else if (skid_valid) begin
        result_valid <= 1'b1;
        skid_valid   <= 1'b0;
      end else begin
        result_valid <= push;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (result_valid && !result_ready) begin
      if (push) begin
        skid_data <= pipe_beat;
      end
    end else if (skid_valid) begin
      result <= skid_data;
    end else if (push) begin
      result <= pipe_beat;
    end
  end

  // a record end always starts a flush that holds off the next sample
  a_flush_holds_feed: assert property (@(posedge clk) disable iff (rst)
    (accept && feed.end_of_record) |=> !feed_ready)
    else $error("feed accepted right after end of record");

  // the record count restarts after the final sample
  a_count_restarts: assert property (@(posedge clk) disable iff (rst)
    (accept && feed.end_of_record) |=> (seen == '0))
    else $error("record count not cleared at end of record");

  // the skid entry only fills behind a stalled output register
  a_skid_behind_output: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid entry holds a beat while output register is empty");

  a_skid_fills_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(result_valid && !result_ready))
    else $error("skid entry filled without a stalled result");

endmodule

`default_nettype wire
